// File: src/wrms_pkg.sv
// Shared types and constants of the waveform RMS meter.
package wrms_pkg;

  localparam int RMS_BITS       = 16;
  localparam int OUT_COUNT_BITS = 24;

  typedef enum logic [1:0] {
    ST_ACCUM = 2'b01,
    ST_CALC  = 2'b10
  } meter_state_t;

  typedef enum logic [2:0] {
    DS_IDLE = 3'b001,
    DS_DIV  = 3'b010,
    DS_ROOT = 3'b100
  } unit_state_t;

endpackage

// File: src/wrms_divsqrt.sv
// Iterative divide then square root unit built around one shared subtractor.
module wrms_divsqrt #(
  parameter int SUM_BITS   = 54,
  parameter int COUNT_BITS = 24,
  parameter int ROOT_BITS  = (SUM_BITS + 1) / 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [SUM_BITS-1:0]   dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  busy,
  output logic [ROOT_BITS-1:0]  root
);

  localparam int RAD_BITS = 2 * ROOT_BITS;
  localparam int SUB_W    = (COUNT_BITS + 1 > ROOT_BITS + 2) ? COUNT_BITS + 1 : ROOT_BITS + 2;
  localparam int CNT_W    = $clog2(SUM_BITS);
  localparam logic [RAD_BITS-1:0] QUO_MASK = RAD_BITS'((64'd1 << SUM_BITS) - 64'd1);

  wrms_pkg::unit_state_t state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [RAD_BITS-1:0]   quo_r, quo_nxt;
  logic [SUB_W-1:0]      rem_r, rem_nxt;
  logic [ROOT_BITS-1:0]  root_r, root_nxt;
  logic [COUNT_BITS-1:0] dsr_r, dsr_nxt;

  logic [SUB_W-1:0] opa, opb, sub_res;
  logic [SUB_W:0]   diff;
  logic             ge;

  always_comb begin
    opa = '0;
    opb = '0;
    if (state_r == wrms_pkg::DS_DIV) begin
      opa = SUB_W'({rem_r[COUNT_BITS-1:0], quo_r[SUM_BITS-1]});
      opb = SUB_W'(dsr_r);
    end else if (state_r == wrms_pkg::DS_ROOT) begin
      opa = SUB_W'({rem_r[ROOT_BITS-1:0], quo_r[RAD_BITS-1 -: 2]});
      opb = SUB_W'({root_r, 2'b01});
    end
  end

  assign diff    = {1'b0, opa} - {1'b0, opb};
  assign ge      = ~diff[SUB_W];
  assign sub_res = ge ? diff[SUB_W-1:0] : opa;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    dsr_nxt   = dsr_r;
    unique case (state_r)
      wrms_pkg::DS_IDLE: begin
        if (start) begin
          quo_nxt   = RAD_BITS'(dividend);
          dsr_nxt   = divisor;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(SUM_BITS - 1);
          state_nxt = wrms_pkg::DS_DIV;
        end
      end
      wrms_pkg::DS_DIV: begin
        rem_nxt = sub_res;
        quo_nxt = {quo_r[RAD_BITS-2:0], ge};
        if (cnt_r == '0) begin
          quo_nxt   = {quo_r[RAD_BITS-2:0], ge} & QUO_MASK;
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = CNT_W'(ROOT_BITS - 1);
          state_nxt = wrms_pkg::DS_ROOT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      wrms_pkg::DS_ROOT: begin
        rem_nxt  = sub_res;
        root_nxt = {root_r[ROOT_BITS-2:0], ge};
        quo_nxt  = {quo_r[RAD_BITS-3:0], 2'b00};
        if (cnt_r == '0) begin
          state_nxt = wrms_pkg::DS_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = wrms_pkg::DS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wrms_pkg::DS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign busy = (state_r != wrms_pkg::DS_IDLE);
  assign root = root_r;

endmodule

// File: src/waveform_rms_meter_core.sv
// Top level of the waveform RMS meter: sample accumulation, result sequencing and output register.
//
// Samples enter on the in_ channel as words of one signed sample and a last flag.
// Each accepted sample is squared, then added into a saturating sum of squares
// while a saturating sample counter advances. Words without last are taken one
// per cycle back to back. A word with last closes the waveform: in_ready drops,
// the sum is divided by the count and the floor square root of that mean is
// taken in one shared subtract unit, one bit per cycle. The divide runs first
// and the root follows; in_ready stays low until the result has moved into
// the output register.
// The result word (rms, sample_count, overflow) waits in an output register
// until taken; accumulation of the next waveform goes on meanwhile, and only
// a further last word stalls behind a result that the receiver has not taken.
// Reset clears the accumulators, the sequencer and out_valid; the block is
// ready in the first cycle after reset.
module waveform_rms_meter_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wrms_pkg::RMS_BITS-1:0]       out_rms,
  output logic [wrms_pkg::OUT_COUNT_BITS-1:0] out_sample_count,
  output logic                                out_overflow
);

  localparam int SUM_RAW   = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
  localparam int SUM_BITS  = (SUM_RAW > 63) ? 63 : SUM_RAW;
  localparam int SQ_BITS   = 2 * SAMPLE_BITS;
  localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  wrms_pkg::meter_state_t state_r, state_nxt;

  logic [SQ_BITS-1:0]    sq_r, sq_nxt;
  logic                  sq_vld_r, sq_vld_nxt;
  logic                  sq_last_r, sq_last_nxt;
  logic [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  sat_r, sat_nxt;
  logic [COUNT_BITS-1:0] res_count_r, res_count_nxt;
  logic                  res_ovf_r, res_ovf_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [wrms_pkg::RMS_BITS-1:0]       out_rms_r, out_rms_nxt;
  logic [wrms_pkg::OUT_COUNT_BITS-1:0] out_count_r, out_count_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic                  accept;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SUM_BITS:0]     sum_ext;
  logic [SUM_BITS-1:0]   sum_add;
  logic                  sat_add;
  logic                  u_start;
  logic                  u_busy;
  logic [ROOT_BITS-1:0]  u_root;

  assign in_ready = (state_r == wrms_pkg::ST_ACCUM) && !(sq_vld_r && sq_last_r);
  assign accept   = in_valid && in_ready;

  assign mag     = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;
  assign sum_ext = {1'b0, sum_r} + {{(SUM_BITS + 1 - SQ_BITS){1'b0}}, sq_r};

  always_comb begin
    sum_add = sum_ext[SUM_BITS-1:0];
    sat_add = 1'b0;
    if (sq_vld_r && sum_ext[SUM_BITS]) begin
      sum_add = {SUM_BITS{1'b1}};
      sat_add = 1'b1;
    end else if (!sq_vld_r) begin
      sum_add = sum_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sq_nxt        = sq_r;
    sq_vld_nxt    = accept;
    sq_last_nxt   = sq_last_r;
    sum_nxt       = sum_add;
    count_nxt     = count_r;
    sat_nxt       = sat_r | sat_add;
    res_count_nxt = res_count_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rms_nxt   = out_rms_r;
    out_count_nxt = out_count_r;
    out_ovf_nxt   = out_ovf_r;
    u_start       = 1'b0;

    if (accept) begin
      sq_nxt      = mag * mag;
      sq_last_nxt = in_last;
      if (count_r == COUNT_MAX) begin
        sat_nxt = 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end

    unique case (state_r)
      wrms_pkg::ST_ACCUM: begin
        if (sq_vld_r && sq_last_r) begin
          u_start       = 1'b1;
          res_count_nxt = count_r;
          res_ovf_nxt   = sat_r | sat_add;
          sum_nxt       = '0;
          count_nxt     = '0;
          sat_nxt       = 1'b0;
          state_nxt     = wrms_pkg::ST_CALC;
        end
      end
      wrms_pkg::ST_CALC: begin
        if (!u_busy && (!out_valid_r || out_ready)) begin
          out_valid_nxt = 1'b1;
          out_rms_nxt   = wrms_pkg::RMS_BITS'(u_root);
          out_count_nxt = wrms_pkg::OUT_COUNT_BITS'(res_count_r);
          out_ovf_nxt   = res_ovf_r;
          state_nxt     = wrms_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_nxt = wrms_pkg::ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrms_pkg::ST_ACCUM;
      sq_vld_r    <= 1'b0;
      sq_last_r   <= 1'b0;
      sum_r       <= '0;
      count_r     <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sq_vld_r    <= sq_vld_nxt;
      sq_last_r   <= sq_last_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sq_r        <= sq_nxt;
    res_count_r <= res_count_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_rms_r   <= out_rms_nxt;
    out_count_r <= out_count_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  wrms_divsqrt #(
    .SUM_BITS  (SUM_BITS),
    .COUNT_BITS(COUNT_BITS),
    .ROOT_BITS (ROOT_BITS)
  ) u_divsqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (u_start),
    .dividend(sum_add),
    .divisor (count_r),
    .busy    (u_busy),
    .root    (u_root)
  );

  assign out_valid        = out_valid_r;
  assign out_rms          = out_rms_r;
  assign out_sample_count = out_count_r;
  assign out_overflow     = out_ovf_r;

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("Input still ready after the last word of a waveform.");

  a_busy_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    u_busy |-> (state_r == wrms_pkg::ST_CALC))
    else $error("Divide and root unit busy outside the calculation state.");

  a_result_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> $past(state_r == wrms_pkg::ST_CALC && !u_busy))
    else $error("Result word raised without a finished calculation.");

endmodule
